FILE: rtl/evr_pkg.sv
// ----------------------------------------------------------------------------
// evr_pkg: shared types and constants of the Euler XYZ vector rotator
// Widths, the CORDIC arctangent table and the rotation slot codes.
// ----------------------------------------------------------------------------
`default_nettype none

package evr_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int COMP_W     = 21;
  // Intermediate components may grow past the Q4.16 range before the final
  // saturation; three rotations can at most triple-double the magnitude.
  localparam int WIDE_W     = COMP_W + 4;
  localparam int TRIG_W     = FRAC_BITS + 2;
  localparam int PROD_W     = WIDE_W + TRIG_W;
  localparam int CORDIC_N   = 30;
  localparam int XW         = 33;
  localparam int ZW         = 32;

  localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(652032874);

  localparam logic signed [COMP_W-1:0] COMP_MAX = {1'b0, {(COMP_W-1){1'b1}}};
  localparam logic signed [COMP_W-1:0] COMP_MIN = {1'b1, {(COMP_W-1){1'b0}}};

  localparam logic [31:0] ATAN_TURN [CORDIC_N] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  // Rotation slots in pipeline order.
  localparam logic [1:0] SLOT_FIRST = 2'd0;
  localparam logic [1:0] SLOT_MID   = 2'd1;
  localparam logic [1:0] SLOT_LAST  = 2'd2;

  // Rotation planes.
  localparam logic [1:0] PLANE_YZ = 2'd0;
  localparam logic [1:0] PLANE_ZX = 2'd1;
  localparam logic [1:0] PLANE_XY = 2'd2;

  typedef logic [ANGLE_BITS-1:0]        ang_t;
  typedef ang_t [2:0]                   ang3_t;
  typedef logic signed [TRIG_W-1:0]     trig_t;
  typedef trig_t [2:0]                  trig3_t;
  typedef logic signed [COMP_W-1:0]     comp_t;
  typedef logic signed [WIDE_W-1:0]     wide_t;

  typedef struct packed {
    logic  mode;
    comp_t x;
    comp_t y;
    comp_t z;
  } vec_t;

  typedef struct packed {
    logic   mode;
    wide_t  x;
    wide_t  y;
    wide_t  z;
    trig3_t sn;
    trig3_t cs;
  } rot_t;

endpackage

`default_nettype wire

FILE: rtl/evr_cordic.sv
// ----------------------------------------------------------------------------
// evr_cordic: pipelined sine and cosine of three binary angles
// One CORDIC iteration per stage, then rounding, clamping and quadrant fold.
// ----------------------------------------------------------------------------
`default_nettype none

module evr_cordic (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  evr_pkg::ang3_t   ang_i,
  input  evr_pkg::vec_t    vec_i,
  output logic             valid_o,
  output evr_pkg::trig3_t  sin_o,
  output evr_pkg::trig3_t  cos_o,
  output evr_pkg::vec_t    vec_o
);
  import evr_pkg::*;

  localparam int RSH = 30 - FRAC_BITS;
  localparam logic signed [XW:0] RND    = (XW+1)'((2**RSH) / 2);
  localparam logic signed [XW:0] ONE_W  = (XW+1)'(2**FRAC_BITS);
  localparam logic signed [XW:0] MONE_W = -ONE_W;

  logic signed [XW-1:0] x_d [CORDIC_N][3];
  logic signed [XW-1:0] y_d [CORDIC_N][3];
  logic signed [ZW-1:0] z_d [CORDIC_N][3];
  logic signed [XW-1:0] x_q [CORDIC_N][3];
  logic signed [XW-1:0] y_q [CORDIC_N][3];
  logic signed [ZW-1:0] z_q [CORDIC_N][3];
  logic [1:0]           quad_q [CORDIC_N][3];
  logic                 vld_q  [CORDIC_N];
  vec_t                 vec_q  [CORDIC_N];

  logic   out_vld_q;
  trig3_t sin_d, cos_d, sin_q, cos_q;
  vec_t   out_vec_q;

  function automatic trig_t to_unit(logic signed [XW-1:0] v);
    logic signed [XW:0] t;
    t = {v[XW-1], v} + RND;
    t = t >>> RSH;
    if (t > ONE_W)       return TRIG_W'(ONE_W);
    else if (t < MONE_W) return TRIG_W'(MONE_W);
    else                 return TRIG_W'(t);
  endfunction

  for (genvar s = 0; s < CORDIC_N; s++) begin : g_stage
    for (genvar a = 0; a < 3; a++) begin : g_axis
      logic signed [XW-1:0] xi, yi, dx, dy;
      logic signed [ZW-1:0] zi;
      logic [1:0]           qi;

      if (s == 0) begin : g_src0
        logic [31:0] turn;
        assign turn = {ang_i[a], {(32-ANGLE_BITS){1'b0}}};
        assign xi = CORDIC_GAIN;
        assign yi = '0;
        assign zi = ZW'({2'b00, turn[29:0]});
        assign qi = turn[31:30];
      end else begin : g_srcn
        assign xi = x_q[s-1][a];
        assign yi = y_q[s-1][a];
        assign zi = z_q[s-1][a];
        assign qi = quad_q[s-1][a];
      end

      assign dx = yi >>> s;
      assign dy = xi >>> s;

      always_comb begin
        if (!zi[ZW-1]) begin
          x_d[s][a] = xi - dx;
          y_d[s][a] = yi + dy;
          z_d[s][a] = zi - ZW'(ATAN_TURN[s]);
        end else begin
          x_d[s][a] = xi + dx;
          y_d[s][a] = yi - dy;
          z_d[s][a] = zi + ZW'(ATAN_TURN[s]);
        end
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          x_q[s][a]    <= x_d[s][a];
          y_q[s][a]    <= y_d[s][a];
          z_q[s][a]    <= z_d[s][a];
          quad_q[s][a] <= qi;
        end
      end
    end

    if (s == 0) begin : g_vld0
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q[s] <= 1'b0;
        end else if (en_i) begin
          vld_q[s] <= valid_i;
        end
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          vec_q[s] <= vec_i;
        end
      end
    end else begin : g_vldn
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q[s] <= 1'b0;
        end else if (en_i) begin
          vld_q[s] <= vld_q[s-1];
        end
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          vec_q[s] <= vec_q[s-1];
        end
      end
    end
  end

  // Rounding, clamping and quadrant fold; the inverse mode negates the sine.
  always_comb begin
    trig_t c, sv, cs, sn;
    for (int a = 0; a < 3; a++) begin
      c  = to_unit(x_q[CORDIC_N-1][a]);
      sv = to_unit(y_q[CORDIC_N-1][a]);
      unique case (quad_q[CORDIC_N-1][a])
        2'd0:    begin cs = c;   sn = sv;  end
        2'd1:    begin cs = -sv; sn = c;   end
        2'd2:    begin cs = -c;  sn = -sv; end
        default: begin cs = sv;  sn = -c;  end
      endcase
      cos_d[a] = cs;
      sin_d[a] = vec_q[CORDIC_N-1].mode ? -sn : sn;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      out_vld_q <= vld_q[CORDIC_N-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q     <= sin_d;
      cos_q     <= cos_d;
      out_vec_q <= vec_q[CORDIC_N-1];
    end
  end

  assign valid_o = out_vld_q;
  assign sin_o   = sin_q;
  assign cos_o   = cos_q;
  assign vec_o   = out_vec_q;

  a_stall_freeze : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(vld_q[0]) && $stable(vld_q[CORDIC_N-1]) && $stable(out_vld_q))
    else $error("CORDIC pipeline moved while stalled");

  a_enter : assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i |=> vld_q[0] == $past(valid_i))
    else $error("CORDIC first stage lost or invented a request");

  a_unit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (cos_q[0] <= TRIG_W'(ONE_W)) && (cos_q[0] >= TRIG_W'(MONE_W))
              && (sin_q[0] <= TRIG_W'(ONE_W)) && (sin_q[0] >= TRIG_W'(MONE_W)))
    else $error("trig value outside the unit range");

endmodule

`default_nettype wire

FILE: rtl/evr_rotate.sv
// ----------------------------------------------------------------------------
// evr_rotate: one plane rotation in two stages
// Products are registered first, then summed, rounded and written back.
// ----------------------------------------------------------------------------
`default_nettype none

module evr_rotate (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [1:0]    slot_i,
  input  logic          valid_i,
  input  evr_pkg::rot_t dat_i,
  output logic          valid_o,
  output evr_pkg::rot_t dat_o
);
  import evr_pkg::*;

  localparam logic signed [PROD_W-1:0] RND = PROD_W'((2**FRAC_BITS) / 2);

  logic [1:0]          plane_d, plane_q;
  wide_t               p, q;
  trig_t               c, s;
  logic signed [PROD_W-1:0] cp_d, sq_d, sp_d, cq_d, cp_q, sq_q, sp_q, cq_q;
  logic                vld_a_q, vld_q;
  rot_t                dat_a_q, dat_d, dat_q;
  logic signed [PROD_W-1:0] np_sum, nq_sum;
  wide_t               np, nq;

  // The first and last slots swap planes between forward and inverse mode.
  always_comb begin
    unique case (slot_i)
      SLOT_FIRST: plane_d = dat_i.mode ? PLANE_XY : PLANE_YZ;
      SLOT_MID:   plane_d = PLANE_ZX;
      default:    plane_d = dat_i.mode ? PLANE_YZ : PLANE_XY;
    endcase
    unique case (plane_d)
      PLANE_YZ: begin p = dat_i.y; q = dat_i.z; c = dat_i.cs[0]; s = dat_i.sn[0]; end
      PLANE_ZX: begin p = dat_i.z; q = dat_i.x; c = dat_i.cs[1]; s = dat_i.sn[1]; end
      default:  begin p = dat_i.x; q = dat_i.y; c = dat_i.cs[2]; s = dat_i.sn[2]; end
    endcase
    cp_d = c * p;
    sq_d = s * q;
    sp_d = s * p;
    cq_d = c * q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_q   <= 1'b0;
    end else if (en_i) begin
      vld_a_q <= valid_i;
      vld_q   <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      plane_q <= plane_d;
      dat_a_q <= dat_i;
      cp_q    <= cp_d;
      sq_q    <= sq_d;
      sp_q    <= sp_d;
      cq_q    <= cq_d;
      dat_q   <= dat_d;
    end
  end

  // Round to nearest with ties toward plus infinity.
  always_comb begin
    np_sum = (cp_q - sq_q + RND) >>> FRAC_BITS;
    nq_sum = (sp_q + cq_q + RND) >>> FRAC_BITS;
    np     = np_sum[WIDE_W-1:0];
    nq     = nq_sum[WIDE_W-1:0];
    dat_d  = dat_a_q;
    unique case (plane_q)
      PLANE_YZ: begin dat_d.y = np; dat_d.z = nq; end
      PLANE_ZX: begin dat_d.z = np; dat_d.x = nq; end
      default:  begin dat_d.x = np; dat_d.y = nq; end
    endcase
  end

  assign valid_o = vld_q;
  assign dat_o   = dat_q;

endmodule

`default_nettype wire

FILE: rtl/euler_xyz_vector_rotator_top.sv
// ----------------------------------------------------------------------------
// euler_xyz_vector_rotator_top: Euler XYZ rotation of a Q4.16 vector
// Stream in a vector and three binary angles, stream out the rotated vector.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle unless stalled and returns one
// rotated vector per request, in order. The pipeline holds 31 CORDIC stages
// that produce the three sines and cosines, three plane rotations of two
// stages each, and one saturation stage. Mode 0 rotates about x, then y,
// then z; mode 1 rotates about z, then y, then x by the negated angles, which
// undoes mode 0. The whole pipeline advances together: it moves whenever the
// output register is empty or being taken, so s_axis_tready falls only while
// a finished result waits at the output and the sink holds m_axis_tready low.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_xyz_vector_rotator_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // Fields from bit 0: mode[0], vec_x[21:1], vec_y[42:22], vec_z[63:43],
  // angle_x[79:64], angle_y[95:80], angle_z[111:96].
  input  logic [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // Fields from bit 0: out_x[20:0], out_y[41:21], out_z[62:42], zero pad[63].
  output logic [63:0]  m_axis_tdata
);
  import evr_pkg::*;

  logic   en;
  ang3_t  ang;
  vec_t   vec_in, cor_vec;
  logic   cor_vld;
  trig3_t cor_sin, cor_cos;
  rot_t   rot_in, rot_a, rot_b, rot_c;
  logic   vld_a, vld_b, vld_c;
  comp_t  sat_x, sat_y, sat_z;
  logic   out_vld_q;
  comp_t  out_x_q, out_y_q, out_z_q;

  // The pipeline stalls only when a result sits at the output unclaimed.
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  assign vec_in.mode = s_axis_tdata[0];
  assign vec_in.x    = s_axis_tdata[21:1];
  assign vec_in.y    = s_axis_tdata[42:22];
  assign vec_in.z    = s_axis_tdata[63:43];
  assign ang[0]      = s_axis_tdata[64 +: ANGLE_BITS];
  assign ang[1]      = s_axis_tdata[80 +: ANGLE_BITS];
  assign ang[2]      = s_axis_tdata[96 +: ANGLE_BITS];

  evr_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .ang_i   (ang),
    .vec_i   (vec_in),
    .valid_o (cor_vld),
    .sin_o   (cor_sin),
    .cos_o   (cor_cos),
    .vec_o   (cor_vec)
  );

  // Widen the components so the intermediate rotations never wrap.
  assign rot_in.mode = cor_vec.mode;
  assign rot_in.x    = WIDE_W'(cor_vec.x);
  assign rot_in.y    = WIDE_W'(cor_vec.y);
  assign rot_in.z    = WIDE_W'(cor_vec.z);
  assign rot_in.sn   = cor_sin;
  assign rot_in.cs   = cor_cos;

  evr_rotate u_rot_first (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .slot_i  (SLOT_FIRST),
    .valid_i (cor_vld),
    .dat_i   (rot_in),
    .valid_o (vld_a),
    .dat_o   (rot_a)
  );

  evr_rotate u_rot_mid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .slot_i  (SLOT_MID),
    .valid_i (vld_a),
    .dat_i   (rot_a),
    .valid_o (vld_b),
    .dat_o   (rot_b)
  );

  evr_rotate u_rot_last (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .slot_i  (SLOT_LAST),
    .valid_i (vld_b),
    .dat_i   (rot_b),
    .valid_o (vld_c),
    .dat_o   (rot_c)
  );

  function automatic comp_t saturate(wide_t v);
    if (v > WIDE_W'(COMP_MAX))      return COMP_MAX;
    else if (v < WIDE_W'(COMP_MIN)) return COMP_MIN;
    else                            return v[COMP_W-1:0];
  endfunction

  assign sat_x = saturate(rot_c.x);
  assign sat_y = saturate(rot_c.y);
  assign sat_z = saturate(rot_c.z);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_x_q <= sat_x;
      out_y_q <= sat_y;
      out_z_q <= sat_z;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, out_z_q, out_y_q, out_x_q};

endmodule

`default_nettype wire
